@@ src/spi_pkg.sv @@
`default_nettype none
package spi_pkg;

  localparam int COORD_W   = 16;
  localparam int FRAC_W    = 16;
  localparam int POS_W     = 32;
  localparam int COUNT_W   = 7;
  localparam int PT_IDX_W  = 6;
  localparam int DIV_W     = 6;
  localparam int DIV_CNT_W = 5;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic        [COUNT_W-1:0] point_count;
  } in_data_t;

  typedef struct packed {
    logic        [PT_IDX_W-1:0] point_index;
    logic signed [POS_W-1:0]    pos_x;
    logic signed [POS_W-1:0]    pos_y;
    logic                       last_point;
  } out_data_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic        [POS_W-1:0]   step_x;
    logic        [POS_W-1:0]   step_y;
  } seg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

@@ src/spi_serial_div.sv @@
`default_nettype none
module spi_serial_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [spi_pkg::POS_W-1:0]  dividend,
  input  wire logic [spi_pkg::DIV_W-1:0]  divisor,
  output logic                            done,
  output logic [spi_pkg::POS_W-1:0]       quotient
);
  import spi_pkg::*;

  logic [POS_W-1:0]     quo_r, quo_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     div_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_W:0]       trial;
  logic [DIV_W:0]       trial_sub;
  logic                 fits;

  // One quotient bit per cycle: the dividend shifts out of the top of the
  // register as the quotient shifts in at the bottom.
  always_comb begin
    trial     = {rem_r, quo_r[POS_W-1]};
    fits      = (trial >= {1'b0, div_r});
    trial_sub = trial - {1'b0, div_r};
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[POS_W-2:0], fits};
      rem_nxt = fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(POS_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

@@ src/spi_point_gen.sv @@
`default_nettype none
module spi_point_gen #(
  parameter int IDX_W = 6
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire spi_pkg::seg_t      seg,
  input  wire logic [IDX_W-1:0]   last_idx,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output spi_pkg::out_data_t      out_data,
  output logic                    done
);
  import spi_pkg::*;

  logic                    valid_r, valid_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [IDX_W-1:0]        last_r;
  logic [POS_W-1:0]        pos_x_r, pos_x_nxt;
  logic [POS_W-1:0]        pos_y_r, pos_y_nxt;
  logic [POS_W-1:0]        step_x_r, step_y_r;
  logic [COORD_W-1:0]      b_x_r, b_y_r;
  logic                    at_last;
  logic                    take;

  assign at_last = (idx_r == last_r);
  assign take    = valid_r && !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    if (start) begin
      valid_nxt = 1'b1;
      idx_nxt   = '0;
      pos_x_nxt = {seg.a_x, {FRAC_W{1'b0}}};
      pos_y_nxt = {seg.a_y, {FRAC_W{1'b0}}};
    end else if (take) begin
      if (at_last) begin
        valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
        if (idx_nxt == last_r) begin
          pos_x_nxt = {b_x_r, {FRAC_W{1'b0}}};
          pos_y_nxt = {b_y_r, {FRAC_W{1'b0}}};
        end else begin
          pos_x_nxt = pos_x_r + step_x_r;
          pos_y_nxt = pos_y_r + step_y_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_x_r <= pos_x_nxt;
    pos_y_r <= pos_y_nxt;
    if (start) begin
      last_r   <= last_idx;
      step_x_r <= seg.step_x;
      step_y_r <= seg.step_y;
      b_x_r    <= seg.b_x;
      b_y_r    <= seg.b_y;
    end
  end

  assign out_valid            = valid_r;
  assign out_data.point_index = PT_IDX_W'(idx_r);
  assign out_data.pos_x       = pos_x_r;
  assign out_data.pos_y       = pos_y_r;
  assign out_data.last_point  = at_last;
  assign done                 = take && at_last;

endmodule
`default_nettype wire

@@ src/segment_point_interpolator.sv @@
// Linear interpolation between two integer end points in Q16.16.
// A request on the input channel (in_valid, in_stall, in_data) carries the
// end points and a point count; counts below two are taken as two and counts
// above MAX_POINTS as MAX_POINTS. The block answers with that many points on
// the output channel (out_valid, out_stall, out_data), in order of index, the
// first equal to the start point and the last, marked by last_point, equal to
// the end point.
// The per-point steps come from two bit-serial dividers working side by side,
// one quotient bit per cycle. Once both have finished, the point generator
// presents the first point, which can be taken in that same cycle. Each
// further point is presented in the cycle after the one before it is taken.
// The next request can be accepted in the cycle after the final point of the
// previous request is taken.
// One request is handled at a time: in_stall stays high from acceptance until
// the final point has been taken.
// While out_stall is high the current point is held unchanged.
// Synchronous reset drops all valids and returns the block to idle, after
// which the next cycle accepts a request.
`default_nettype none
module segment_point_interpolator #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire spi_pkg::in_data_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output spi_pkg::out_data_t       out_data
);
  import spi_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);

  state_t               state_r, state_nxt;
  logic                 accept;
  logic [COUNT_W-1:0]   count_sat;
  logic [COUNT_W-1:0]   count_m1;
  logic [COORD_W:0]     diff_x, diff_y;
  logic [COORD_W:0]     mag_x, mag_y;
  logic [COORD_W-1:0]   a_x_r, a_y_r, b_x_r, b_y_r;
  logic [IDX_W-1:0]     last_idx_r;
  logic                 neg_x_r, neg_y_r;
  logic                 div_x_done, div_y_done;
  logic [POS_W-1:0]     quo_x, quo_y;
  logic                 gen_start;
  logic                 gen_done;
  seg_t                 seg;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    count_sat = in_data.point_count;
    if (in_data.point_count < COUNT_W'(2)) begin
      count_sat = COUNT_W'(2);
    end else if (in_data.point_count > COUNT_W'(MAX_POINTS)) begin
      count_sat = COUNT_W'(MAX_POINTS);
    end
    count_m1 = count_sat - 1'b1;
    diff_x   = {in_data.end_x[COORD_W-1], in_data.end_x}
             - {in_data.start_x[COORD_W-1], in_data.start_x};
    diff_y   = {in_data.end_y[COORD_W-1], in_data.end_y}
             - {in_data.start_y[COORD_W-1], in_data.start_y};
    mag_x    = diff_x[COORD_W] ? -diff_x : diff_x;
    mag_y    = diff_y[COORD_W] ? -diff_y : diff_y;
  end

  spi_serial_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend ({mag_x[COORD_W-1:0], {FRAC_W{1'b0}}}),
    .divisor  (count_m1[DIV_W-1:0]),
    .done     (div_x_done),
    .quotient (quo_x)
  );

  spi_serial_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend ({mag_y[COORD_W-1:0], {FRAC_W{1'b0}}}),
    .divisor  (count_m1[DIV_W-1:0]),
    .done     (div_y_done),
    .quotient (quo_y)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      a_x_r      <= in_data.start_x;
      a_y_r      <= in_data.start_y;
      b_x_r      <= in_data.end_x;
      b_y_r      <= in_data.end_y;
      neg_x_r    <= diff_x[COORD_W];
      neg_y_r    <= diff_y[COORD_W];
      last_idx_r <= count_m1[IDX_W-1:0];
    end
  end

  always_comb begin
    seg.a_x    = a_x_r;
    seg.a_y    = a_y_r;
    seg.b_x    = b_x_r;
    seg.b_y    = b_y_r;
    seg.step_x = neg_x_r ? -quo_x : quo_x;
    seg.step_y = neg_y_r ? -quo_y : quo_y;
  end

  always_comb begin
    state_nxt = state_r;
    gen_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_x_done && div_y_done) begin
          gen_start = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (gen_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  spi_point_gen #(
    .IDX_W (IDX_W)
  ) u_point_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (gen_start),
    .seg       (seg),
    .last_idx  (last_idx_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .done      (gen_done)
  );

endmodule
`default_nettype wire
